// ----- rtl/core/coeff_level_remaining_decoder_top_assert.svh -----
// Assertion macros for the coefficient level decoder.
// Included by the top level; needs a clock and an active-low reset in scope.
`ifndef COEFF_LEVEL_REMAINING_DECODER_TOP_ASSERT_SVH
`define COEFF_LEVEL_REMAINING_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define CLRD_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("clrd: same-cycle check failed");

// next-cycle implication
`define CLRD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("clrd: next-cycle check failed");

`endif

// ----- rtl/core/clrd_pkg.sv -----
// Shared types and constants for the coefficient level decoder.
// No dependencies; imported by every module of the block.
package clrd_pkg;

    localparam int WIN_W           = 64;
    localparam int VAL_W           = 32;
    localparam int RICE_W          = 6;
    localparam int STAT_W          = 8;
    localparam int SB_W            = 6;
    localparam int DEPTH_W         = 5;
    localparam int USED_W          = 7;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    localparam int PREFIX_MAX      = 4;
    localparam int RICE_CAP_PLAIN  = 4;
    localparam int RICE_BUMP_LIMIT = 31;
    localparam int GROW_MULT       = 3;
    localparam int RANGE_MIN       = 15;
    localparam int RANGE_OFS       = 6;
    localparam int EXT_LIMIT       = 28;
    localparam int CMAX_SAT_RICE   = VAL_W - 2;
    localparam int STAT_SH_LIMIT   = 34;

    localparam logic [1:0] COMP_LUMA = 2'd0;

    localparam logic [1:0] REG_PERSIST      = 2'd0;
    localparam logic [1:0] REG_DEPTH_LUMA   = 2'd1;
    localparam logic [1:0] REG_DEPTH_CHROMA = 2'd2;

    typedef struct packed {
        logic               persist;
        logic [DEPTH_W-1:0] depth_luma;
        logic [DEPTH_W-1:0] depth_chroma;
    } cfg_t;

    typedef struct packed {
        logic              new_slice;
        logic              new_block;
        logic [SB_W-1:0]   subblock_index;
        logic [1:0]        base_level;
        logic [1:0]        comp_index;
        logic              transform_skip;
        logic              quant_bypass;
        logic [WIN_W-1:0]  bin_window;
    } item_t;

    typedef struct packed {
        logic [3:0][STAT_W-1:0] stats;
        logic [VAL_W-1:0]       prev_abs;
        logic [RICE_W-1:0]      prev_rice;
        logic [SB_W-1:0]        prev_sb;
        logic                   prev_valid;
    } ctx_t;

    typedef struct packed {
        logic              fire;
        logic              new_slice;
        logic              new_block;
        logic              ok;
        logic              stat_en;
        logic [1:0]        cls;
        logic [VAL_W-1:0]  val;
        logic [VAL_W-1:0]  level;
        logic [RICE_W-1:0] rice;
        logic [SB_W-1:0]   sb;
    } commit_t;

    typedef struct packed {
        logic [VAL_W-1:0]  level_value;
        logic [USED_W-1:0] bins_used;
        logic              window_short;
    } result_t;

endpackage

// ----- rtl/core/clrd_regs.sv -----
// Configuration register file behind the APB-style port.
// Depends on clrd_pkg for register indexes and the config struct.
module clrd_regs
    import clrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_PERSIST:      cfg_next.persist      = pwdata[0];
                REG_DEPTH_LUMA:   cfg_next.depth_luma   = pwdata[DEPTH_W-1:0];
                REG_DEPTH_CHROMA: cfg_next.depth_chroma = pwdata[DEPTH_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PERSIST:      prdata = DATA_W'(cfg_reg.persist);
            REG_DEPTH_LUMA:   prdata = DATA_W'(cfg_reg.depth_luma);
            REG_DEPTH_CHROMA: prdata = DATA_W'(cfg_reg.depth_chroma);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.persist      <= 1'b0;
            cfg_reg.depth_luma   <= DEPTH_W'(8);
            cfg_reg.depth_chroma <= DEPTH_W'(8);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/clrd_decode.sv -----
// Combinational debinarisation of one level: Rice parameter derivation,
// prefix and escape parsing, suffix extraction and saturating sum.
// Depends on clrd_pkg; purely combinational.
module clrd_decode
    import clrd_pkg::*;
#(
    parameter int WINDOW_BINS = 64
)
(
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    input  ctx_t    ctx,
    output result_t res,
    output commit_t commit
);

    logic               luma;
    logic               persist;
    logic               first;
    logic               bump;
    logic               p_full;
    logic               term;
    logic               unterm;
    logic               short_f;
    logic               a_sat;
    logic               suf_sat;
    logic               cmax_sat;
    logic               val_sat;
    logic [1:0]         cls;
    logic [1:0]         p_low;
    logic [STAT_W-1:0]  stat_eff;
    logic [VAL_W-1:0]   last_abs;
    logic [VAL_W-1:0]   a_val;
    logic [VAL_W-1:0]   cmax_val;
    logic [VAL_W-1:0]   ones_m;
    logic [VAL_W-1:0]   val;
    logic [VAL_W-1:0]   level;
    logic [RICE_W-1:0]  last_rice;
    logic [RICE_W-1:0]  rice_inc;
    logic [RICE_W-1:0]  rice;
    logic [5:0]         run_ones;
    logic [5:0]         m_len;
    logic [5:0]         depth6;
    logic [5:0]         range_len;
    logic [DEPTH_W-1:0] depth;
    logic [3:0]         max_ext;
    logic [3:0]         e_len;
    logic [6:0]         k_len;
    logic [6:0]         start;
    logic [6:0]         len;
    logic [7:0]         total;
    logic [7:0]         mk;
    logic [33:0]        thr;
    logic [33:0]        p_shift;
    logic [33:0]        sum;
    logic [32:0]        lsum;
    logic [WIN_W-1:0]   win_shift;
    logic [WIN_W-1:0]   suf;

    // leading ones after the four prefix bins; the last write is the earliest zero
    always_comb
    begin
        run_ones = 6'(WIN_W - PREFIX_MAX);
        for (int i = 0; i < WIN_W - PREFIX_MAX; i++)
        begin
            if (!item.bin_window[i])
                run_ones = 6'(WIN_W - PREFIX_MAX - 1 - i);
        end
    end

    always_comb
    begin
        luma     = (item.comp_index == COMP_LUMA);
        persist  = cfg.persist;
        cls      = {luma, item.transform_skip | item.quant_bypass};
        stat_eff = item.new_slice ? '0 : ctx.stats[cls];

        first     = !ctx.prev_valid || item.new_block || (item.subblock_index != ctx.prev_sb);
        last_abs  = first ? '0 : ctx.prev_abs;
        last_rice = first ? (persist ? stat_eff[STAT_W-1:2] : '0) : ctx.prev_rice;

        thr      = 34'(GROW_MULT) << last_rice;
        bump     = (last_rice < RICE_W'(RICE_BUMP_LIMIT)) && ({2'b00, last_abs} > thr);
        rice_inc = last_rice + RICE_W'(bump);
        rice     = (!persist && rice_inc > RICE_W'(RICE_CAP_PLAIN)) ?
                   RICE_W'(RICE_CAP_PLAIN) : rice_inc;
        k_len    = 7'(rice) + 7'd1;

        // escape length limit from the transform range
        depth     = luma ? cfg.depth_luma : cfg.depth_chroma;
        depth6    = 6'(depth) + 6'(RANGE_OFS);
        range_len = (depth6 > 6'(RANGE_MIN)) ? depth6 : 6'(RANGE_MIN);
        max_ext   = (range_len < 6'(EXT_LIMIT)) ? 4'(6'(EXT_LIMIT) - range_len) : '0;
        term      = run_ones < {2'b00, max_ext};
        e_len     = term ? run_ones[3:0] : max_ext;

        p_full = &item.bin_window[WIN_W-1:WIN_W-PREFIX_MAX];
        if (!item.bin_window[WIN_W-1])
            p_low = 2'd0;
        else if (!item.bin_window[WIN_W-2])
            p_low = 2'd1;
        else if (!item.bin_window[WIN_W-3])
            p_low = 2'd2;
        else
            p_low = 2'd3;

        m_len   = '0;
        mk      = '0;
        ones_m  = '0;
        p_shift = '0;
        unterm  = 1'b0;
        if (!p_full)
        begin
            start   = 7'(p_low) + 7'd1;
            len     = 7'(rice);
            p_shift = 34'(p_low) << rice;
            a_sat   = (p_low != 2'd0) && ((rice >= RICE_W'(VAL_W)) || (|p_shift[33:32]));
            a_val   = p_shift[VAL_W-1:0];
        end
        else
        begin
            if (!persist)
            begin
                m_len  = run_ones;
                start  = 7'(PREFIX_MAX + 1) + 7'(run_ones);
                len    = k_len + 7'(run_ones);
                unterm = (8'(PREFIX_MAX) + 8'(run_ones)) >= 8'(WINDOW_BINS);
            end
            else
            begin
                m_len = 6'(e_len);
                start = 7'(PREFIX_MAX) + 7'(e_len) + 7'(term);
                len   = term ? (k_len + 7'(e_len)) : 7'(range_len);
            end
            mk     = 8'(m_len) + 8'(k_len);
            a_sat  = (m_len != '0) && (mk >= 8'(VAL_W + 1));
            ones_m = ~({VAL_W{1'b1}} << m_len);
            a_val  = ones_m << k_len;
        end

        total   = 8'(start) + 8'(len);
        short_f = unterm || (total > 8'(WINDOW_BINS));

        // suffix: len bins starting at bin start
        win_shift = item.bin_window << start;
        suf       = (len == '0) ? '0 : (win_shift >> (7'(WIN_W) - len));
        suf_sat   = |suf[WIN_W-1:VAL_W];

        cmax_sat = rice >= RICE_W'(CMAX_SAT_RICE);
        cmax_val = VAL_W'(PREFIX_MAX) << rice[4:0];

        sum = 34'(a_val) + 34'(suf[VAL_W-1:0]) + (p_full ? 34'(cmax_val) : 34'd0);
        val_sat = a_sat || suf_sat || (p_full && cmax_sat) || (|sum[33:32]);
        val     = val_sat ? '1 : sum[VAL_W-1:0];

        lsum  = 33'(val) + 33'(item.base_level);
        level = lsum[VAL_W] ? '1 : lsum[VAL_W-1:0];

        res.level_value  = short_f ? '0 : val;
        res.bins_used    = short_f ? '0 : total[USED_W-1:0];
        res.window_short = short_f;

        commit.fire      = fire;
        commit.new_slice = item.new_slice;
        commit.new_block = item.new_block;
        commit.ok        = !short_f;
        commit.stat_en   = persist && first;
        commit.cls       = cls;
        commit.val       = val;
        commit.level     = level;
        commit.rice      = rice;
        commit.sb        = item.subblock_index;
    end

endmodule

// ----- rtl/core/clrd_ctx.sv -----
// Decoding context: four adaptation statistics and the last level, Rice
// parameter and sub-block. Depends on clrd_pkg.
module clrd_ctx
    import clrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  commit_t commit,
    output ctx_t    ctx
);

    logic [3:0][STAT_W-1:0] stats_reg;
    logic [3:0][STAT_W-1:0] stats_next;
    logic [VAL_W-1:0]       prev_abs_reg;
    logic [VAL_W-1:0]       prev_abs_next;
    logic [RICE_W-1:0]      prev_rice_reg;
    logic [RICE_W-1:0]      prev_rice_next;
    logic [SB_W-1:0]        prev_sb_reg;
    logic [SB_W-1:0]        prev_sb_next;
    logic                   prev_valid_reg;
    logic                   prev_valid_next;

    logic [STAT_W-1:0]      stat_cur;
    logic [STAT_W-1:0]      stat_new;
    logic [5:0]             sh;
    logic                   grow;
    logic                   shrink;

    always_comb
    begin
        stat_cur = commit.new_slice ? '0 : stats_reg[commit.cls];
        sh       = stat_cur[STAT_W-1:2];
        if (sh >= 6'(STAT_SH_LIMIT))
        begin
            grow   = 1'b0;
            shrink = 1'b1;
        end
        else
        begin
            grow   = {3'b000, commit.val} >= (35'(GROW_MULT) << sh);
            shrink = {2'b00, commit.val, 1'b0} < (35'd1 << sh);
        end

        // saturate at both ends
        if (grow)
            stat_new = (stat_cur != '1) ? stat_cur + 1'b1 : stat_cur;
        else if (shrink && stat_cur != '0)
            stat_new = stat_cur - 1'b1;
        else
            stat_new = stat_cur;

        stats_next      = stats_reg;
        prev_abs_next   = prev_abs_reg;
        prev_rice_next  = prev_rice_reg;
        prev_sb_next    = prev_sb_reg;
        prev_valid_next = prev_valid_reg;
        if (commit.fire)
        begin
            if (commit.new_slice)
                stats_next = '0;
            if (commit.new_block)
                prev_valid_next = 1'b0;
            if (commit.ok)
            begin
                if (commit.stat_en)
                    stats_next[commit.cls] = stat_new;
                prev_abs_next   = commit.level;
                prev_rice_next  = commit.rice;
                prev_sb_next    = commit.sb;
                prev_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg      <= '0;
            prev_abs_reg   <= '0;
            prev_rice_reg  <= '0;
            prev_sb_reg    <= '0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            stats_reg      <= stats_next;
            prev_abs_reg   <= prev_abs_next;
            prev_rice_reg  <= prev_rice_next;
            prev_sb_reg    <= prev_sb_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    assign ctx.stats      = stats_reg;
    assign ctx.prev_abs   = prev_abs_reg;
    assign ctx.prev_rice  = prev_rice_reg;
    assign ctx.prev_sb    = prev_sb_reg;
    assign ctx.prev_valid = prev_valid_reg;

endmodule

// ----- rtl/core/coeff_level_remaining_decoder_top.sv -----
// Pipeline: the accepted item is held in the input register (s1_reg) and decoded
// combinationally into the result register (res_reg) when that is free or draining.
// Throughput: one item per cycle unless the output is stalled by out_ready; the context
// feedback (last level, Rice parameter, statistics) is updated in the same cycle the item
// moves into the result register. Reset (rst_n low, asynchronous) clears statistics,
// context, configuration and both valid flags; no clearing pass is needed.
module coeff_level_remaining_decoder_top
    import clrd_pkg::*;
#(
    parameter int WINDOW_BINS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              new_slice,
    input  logic              new_block,
    input  logic [SB_W-1:0]   subblock_index,
    input  logic [1:0]        base_level,
    input  logic [1:0]        comp_index,
    input  logic              transform_skip,
    input  logic              quant_bypass,
    input  logic [WIN_W-1:0]  bin_window,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [VAL_W-1:0]  level_value,
    output logic [USED_W-1:0] bins_used,
    output logic              window_short
);

    cfg_t    cfg;
    ctx_t    ctx;
    commit_t commit;
    result_t res;

    item_t   s1_reg;
    item_t   s1_next;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    s1_adv;
    logic    in_fire;

    clrd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clrd_decode #(
        .WINDOW_BINS (WINDOW_BINS)
    ) u_decode (
        .fire   (s1_adv),
        .item   (s1_reg),
        .cfg    (cfg),
        .ctx    (ctx),
        .res    (res),
        .commit (commit)
    );

    clrd_ctx u_ctx (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .ctx    (ctx)
    );

    // advance the held item whenever the result register is free or draining
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_next.new_slice      = new_slice;
        s1_next.new_block      = new_block;
        s1_next.subblock_index = subblock_index;
        s1_next.base_level     = base_level;
        s1_next.comp_index     = comp_index;
        s1_next.transform_skip = transform_skip;
        s1_next.quant_bypass   = quant_bypass;
        s1_next.bin_window     = bin_window;
        s1_valid_next          = in_fire || (s1_valid_reg && !s1_adv);
        res_next               = res;
        out_valid_next         = s1_adv || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_reg <= s1_next;
        if (s1_adv)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign level_value  = res_reg.level_value;
    assign bins_used    = res_reg.bins_used;
    assign window_short = res_reg.window_short;

`include "coeff_level_remaining_decoder_top_assert.svh"

    `CLRD_ASSERT_IMPL(a_short_zero, clk, rst_n, out_valid_reg && res_reg.window_short,
        res_reg.level_value == '0 && res_reg.bins_used == '0)
    `CLRD_ASSERT_IMPL(a_used_bound, clk, rst_n, out_valid_reg && !res_reg.window_short,
        res_reg.bins_used != '0 && res_reg.bins_used <= USED_W'(WINDOW_BINS))
    `CLRD_ASSERT_NEXT(a_ctx_valid, clk, rst_n, commit.fire && commit.ok, ctx.prev_valid)
    `CLRD_ASSERT_IMPL(a_stall_only, clk, rst_n, !in_ready,
        s1_valid_reg && out_valid_reg && !out_ready)

endmodule
